// ===== src/spfk_pkg.sv =====
package spfk_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int LOG_FRAC    = 20;
	localparam int LOG_W       = 6 + LOG_FRAC;
	localparam int LOG_LAT     = 2 + LOG_FRAC;
	localparam int EXP_LAT     = 2 + LOG_FRAC;
	localparam int SUM_W       = 40;
	localparam int ALPHA_W     = 21;
	localparam int ALPHA_FRAC  = 16;
	localparam int SCALE_FRAC  = 16;
	localparam int ALPHA_ONE   = 65536;
	localparam int ALPHA_MAX   = 1048576;
	localparam int ALPHA_RESET = 131072;

	// log2 offsets folded into the force and energy exponents
	localparam logic signed [SUM_W-1:0] LF_BIAS =
		SUM_W'(2 * (FRAC_BITS << LOG_FRAC) - (SCALE_FRAC << LOG_FRAC));
	localparam logic signed [SUM_W-1:0] LE_BIAS =
		SUM_W'((ALPHA_FRAC << LOG_FRAC) - (SCALE_FRAC << LOG_FRAC));
	localparam logic [LOG_W-1:0] LOG_ONE = LOG_W'(FRAC_BITS << LOG_FRAC);

	typedef struct packed {
		logic                 contact;
		logic                 scale_nz;
		logic [2:0]           neg;
		logic [31:0]          ax;
		logic [31:0]          ay;
		logic [31:0]          az;
		logic [ALPHA_W-1:0]   alpha;
	} base_t;

	typedef struct packed {
		base_t              b;
		logic [LOG_W-1:0]   lr2;
		logic [LOG_W-1:0]   lsig;
		logic [LOG_W-1:0]   lsc;
		logic [LOG_W-1:0]   lal;
	} ctx_t;

	typedef struct packed {
		ctx_t c;
		logic u_zero;
	} ulog_t;

	typedef struct packed {
		logic        contact;
		logic        scale_nz;
		logic        fz;
		logic        ez;
		logic [2:0]  neg;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
	} fin_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = x;
		r = '0;
		b = 64'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-n) in Q2.30 from the truncated square root chain starting at 2.0
	function automatic logic [31:0] exp2_root(input int n);
		logic [63:0] c;
		c = 64'd2 << 30;
		for (int j = 0; j < n; j++) begin
			c = isqrt64(c << 30);
		end
		return c[31:0];
	endfunction

endpackage

// ===== src/spfk_log2.sv =====
module spfk_log2 (
	input  logic                          clk,
	input  logic                          en,
	input  logic [63:0]                   x,
	output logic [spfk_pkg::LOG_W-1:0]    y
);

	localparam int Steps = spfk_pkg::LOG_FRAC;

	logic [5:0]        msb;
	logic [5:0]        msb_s1;
	logic [63:0]       x_s1;
	logic [63:0]       nrm;
	logic [30:0]       m_s  [0:Steps];
	logic [Steps-1:0]  fr_s [0:Steps];
	logic [5:0]        ip_s [0:Steps];

	always_comb begin
		msb = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) msb = 6'(i);
		end
	end

	always_comb begin
		if (msb_s1 >= 6'd30) begin
			nrm = x_s1 >> (msb_s1 - 6'd30);
		end else begin
			nrm = x_s1 << (6'd30 - msb_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			msb_s1  <= msb;
			x_s1    <= x;
			m_s[0]  <= nrm[30:0];
			ip_s[0] <= msb_s1;
			fr_s[0] <= '0;
		end
	end

	// one squaring per stage yields one fraction bit
	for (genvar i = 1; i <= Steps; i++) begin : g_sq
		localparam logic [Steps-1:0] Bit = Steps'(1) << (Steps - i);
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = 62'(m_s[i-1]) * 62'(m_s[i-1]);
		assign t  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				ip_s[i] <= ip_s[i-1];
				if (t[31]) begin
					m_s[i]  <= t[31:1];
					fr_s[i] <= fr_s[i-1] | Bit;
				end else begin
					m_s[i]  <= t[30:0];
					fr_s[i] <= fr_s[i-1];
				end
			end
		end
	end

	assign y = {ip_s[Steps], fr_s[Steps]};

endmodule

// ===== src/spfk_exp2.sv =====
module spfk_exp2 (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [spfk_pkg::SUM_W-1:0]    y,
	input  logic [31:0]                          cap,
	output logic [31:0]                          v
);

	localparam int Steps = spfk_pkg::LOG_FRAC;
	localparam int W     = spfk_pkg::SUM_W;
	localparam logic signed [W-1:0] YLo  = -W'(100 * (1 << Steps));
	localparam logic signed [W-1:0] YHi  = W'(63 * (1 << Steps));
	localparam logic signed [W-1:0] Bias = W'(128 * (1 << Steps));

	logic signed [W-1:0]  yc;
	logic [W-1:0]         uy;
	logic signed [8:0]    k;
	logic [30:0]          r_s [0:Steps];
	logic signed [8:0]    k_s [0:Steps];
	logic [Steps-1:0]     f_s [0:Steps];
	logic signed [9:0]    e;
	logic [6:0]           ne;
	logic [63:0]          wide;
	logic [30:0]          nar;
	logic [31:0]          res;
	logic [31:0]          v_q;

	always_comb begin
		if (y < YLo) begin
			yc = YLo;
		end else if (y > YHi) begin
			yc = YHi;
		end else begin
			yc = y;
		end
		uy = W'(yc + Bias);
		k  = signed'({1'b0, uy[Steps+7:Steps]}) - 9'sd128;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= 31'h4000_0000;
			k_s[0] <= k;
			f_s[0] <= uy[Steps-1:0];
		end
	end

	for (genvar i = 1; i <= Steps; i++) begin : g_mul
		localparam logic [30:0] Root = 31'(spfk_pkg::exp2_root(i));
		logic [61:0] prod;
		assign prod = 62'(r_s[i-1]) * 62'(Root);
		always_ff @(posedge clk) begin
			if (en) begin
				k_s[i] <= k_s[i-1];
				f_s[i] <= f_s[i-1];
				r_s[i] <= f_s[i-1][Steps-i] ? prod[60:30] : r_s[i-1];
			end
		end
	end

	// scale Q1.30 mantissa to the output format, then clamp
	always_comb begin
		e    = 10'(k_s[Steps]) + 10'(spfk_pkg::FRAC_BITS) - 10'sd30;
		ne   = 7'(-e);
		wide = 64'(r_s[Steps]) << e[5:0];
		nar  = r_s[Steps] >> ne[5:0];
		if (!e[9]) begin
			if (e > 10'sd32 || wide > 64'(cap)) begin
				res = cap;
			end else begin
				res = wide[31:0];
			end
		end else if (ne >= 7'd63) begin
			res = '0;
		end else if (32'(nar) > cap) begin
			res = cap;
		end else begin
			res = 32'(nar);
		end
	end

	always_ff @(posedge clk) begin
		if (en) v_q <= res;
	end

	assign v = v_q;

endmodule

// ===== src/soft_pair_force_kernel.sv =====
// Channel  | Signals                                          | Handshake
// pair     | delta_x/y/z, radius_first/second, bond_scale     | pair_valid / pair_stall
// force    | in_contact, force_over_distance, force_x/y/z,    | force_valid / force_stall
//          | pair_energy                                      |
// softness | softness_exponent                                | softness_valid / softness_ready
//
// One pair per cycle while no stalled result holds the pipeline.
// The pipeline holds two log2 passes and two exp2 passes of 20 squaring or
// multiply stages each, plus front squares and back force products.
// Reset clears the valid chain and sets the exponent to 2.0.
// A stalled result freezes the whole pipeline; pair_stall is high exactly then.
module soft_pair_force_kernel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	output logic                pair_stall,
	input  logic signed [31:0]  delta_x,
	input  logic signed [31:0]  delta_y,
	input  logic signed [31:0]  delta_z,
	input  logic [30:0]         radius_first,
	input  logic [30:0]         radius_second,
	input  logic [16:0]         bond_scale,
	input  logic                softness_valid,
	output logic                softness_ready,
	input  logic [20:0]         softness_exponent,
	output logic                force_valid,
	input  logic                force_stall,
	output logic                in_contact,
	output logic [31:0]         force_over_distance,
	output logic signed [31:0]  force_x,
	output logic signed [31:0]  force_y,
	output logic signed [31:0]  force_z,
	output logic [16:0]         pair_energy
);

	localparam int LogLat = spfk_pkg::LOG_LAT;
	localparam int ExpLat = spfk_pkg::EXP_LAT;
	localparam int Total  = 3 + 2 * LogLat + 2 * ExpLat + 3;
	localparam int W      = spfk_pkg::SUM_W;
	localparam int LW     = spfk_pkg::LOG_W;
	localparam int AW     = spfk_pkg::ALPHA_W;

	logic                 en;
	logic [Total-1:0]     vld_q;
	logic [AW-1:0]        alpha_q;

	// front end
	logic [31:0]          ax_s1, ay_s1, az_s1, sigma_s1;
	logic [2:0]           neg_s1;
	logic [16:0]          scale_s1;
	logic [AW-1:0]        alpha_s1;
	logic [63:0]          sqx_s2, sqy_s2, sqz_s2, sqs_s2;
	logic [31:0]          ax_s2, ay_s2, az_s2, sigma_s2;
	logic [2:0]           neg_s2;
	logic [16:0]          scale_s2;
	logic [AW-1:0]        alpha_s2;
	logic [63:0]          rsq;
	logic [63:0]          rsq_s3, sigsq_s3;
	logic [31:0]          sigma_s3;
	logic [16:0]          scale_s3;
	spfk_pkg::base_t      base_s3;

	// log and exp sections
	logic [LW-1:0]        lr2, ls2, lsig, lsc, lal, lu;
	spfk_pkg::base_t      side_b_s [LogLat];
	spfk_pkg::ctx_t       ctx;
	spfk_pkg::ctx_t       side_c_s [ExpLat];
	logic signed [W-1:0]  dif, y_ros;
	logic [31:0]          ros;
	logic [16:0]          u;
	spfk_pkg::ulog_t      uctx;
	spfk_pkg::ulog_t      side_d_s [LogLat];
	spfk_pkg::ulog_t      d_out;
	logic [LW-1:0]        nu;
	logic [AW-1:0]        am1;
	logic [46:0]          pa_full, pe_full;
	logic [29:0]          pa_s70, pe_s70;
	spfk_pkg::ulog_t      ctx_s70;
	logic [AW-1:0]        am1_s70;
	logic signed [W-1:0]  lf, le;
	spfk_pkg::fin_t       fin;
	spfk_pkg::fin_t       side_f_s [ExpLat];
	spfk_pkg::fin_t       f_out;
	logic [31:0]          fp, en_raw, fp_m;
	logic [16:0]          en_m;

	// back end
	logic                 contact_s93;
	logic [31:0]          fp_s93;
	logic [16:0]          en_s93;
	logic [2:0]           neg_s93;
	logic [47:0]          px_s93, py_s93, pz_s93;
	logic                 contact_s94;
	logic [31:0]          fp_s94;
	logic [16:0]          en_s94;
	logic [31:0]          fx_s94, fy_s94, fz_s94;

	function automatic logic [31:0] sat_comp(input logic [47:0] p, input logic neg);
		logic [31:0] pc;
		if (neg) begin
			pc = (p > 48'h8000_0000) ? 32'h8000_0000 : p[31:0];
			return 32'(-pc);
		end
		return (p > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
	endfunction

	assign en             = !(force_valid && force_stall);
	assign pair_stall     = !en;
	assign softness_ready = 1'b1;
	assign force_valid    = vld_q[Total-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= AW'(spfk_pkg::ALPHA_RESET);
		end else if (softness_valid) begin
			alpha_q <= softness_exponent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Total-2:0], pair_valid};
		end
	end

	// stage 1: magnitudes, contact distance, exponent clamp
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= delta_x[31] ? 32'(-delta_x) : 32'(delta_x);
			ay_s1    <= delta_y[31] ? 32'(-delta_y) : 32'(delta_y);
			az_s1    <= delta_z[31] ? 32'(-delta_z) : 32'(delta_z);
			neg_s1   <= {delta_z[31], delta_y[31], delta_x[31]};
			sigma_s1 <= 32'(radius_first) + 32'(radius_second);
			scale_s1 <= bond_scale;
			if (alpha_q < AW'(spfk_pkg::ALPHA_ONE)) begin
				alpha_s1 <= AW'(spfk_pkg::ALPHA_ONE);
			end else if (alpha_q > AW'(spfk_pkg::ALPHA_MAX)) begin
				alpha_s1 <= AW'(spfk_pkg::ALPHA_MAX);
			end else begin
				alpha_s1 <= alpha_q;
			end
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= 64'(ax_s1) * 64'(ax_s1);
			sqy_s2   <= 64'(ay_s1) * 64'(ay_s1);
			sqz_s2   <= 64'(az_s1) * 64'(az_s1);
			sqs_s2   <= 64'(sigma_s1) * 64'(sigma_s1);
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			az_s2    <= az_s1;
			neg_s2   <= neg_s1;
			sigma_s2 <= sigma_s1;
			scale_s2 <= scale_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// stage 3: squared distance and overlap test
	assign rsq = sqx_s2 + sqy_s2 + sqz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rsq_s3           <= rsq;
			sigsq_s3         <= sqs_s2;
			sigma_s3         <= sigma_s2;
			scale_s3         <= scale_s2;
			base_s3.contact  <= (rsq != 64'd0) && (rsq < sqs_s2);
			base_s3.scale_nz <= scale_s2 != 17'd0;
			base_s3.neg      <= neg_s2;
			base_s3.ax       <= ax_s2;
			base_s3.ay       <= ay_s2;
			base_s3.az       <= az_s2;
			base_s3.alpha    <= alpha_s2;
		end
	end

	spfk_log2 u_log_rsq   (.clk(clk), .en(en), .x(rsq_s3),          .y(lr2));
	spfk_log2 u_log_sigsq (.clk(clk), .en(en), .x(sigsq_s3),        .y(ls2));
	spfk_log2 u_log_sigma (.clk(clk), .en(en), .x(64'(sigma_s3)),   .y(lsig));
	spfk_log2 u_log_scale (.clk(clk), .en(en), .x(64'(scale_s3)),   .y(lsc));
	spfk_log2 u_log_alpha (.clk(clk), .en(en), .x(64'(base_s3.alpha)), .y(lal));

	always_ff @(posedge clk) begin
		if (en) begin
			side_b_s[0] <= base_s3;
			for (int j = 1; j < LogLat; j++) side_b_s[j] <= side_b_s[j-1];
		end
	end

	// r/sigma = 2^-((log2 sigma^2 - log2 r^2) / 2), halved by an arithmetic shift
	always_comb begin
		dif      = W'(signed'({1'b0, ls2})) - W'(signed'({1'b0, lr2}));
		y_ros    = -(dif >>> 1);
		ctx.b    = side_b_s[LogLat-1];
		ctx.lr2  = lr2;
		ctx.lsig = lsig;
		ctx.lsc  = lsc;
		ctx.lal  = lal;
	end

	spfk_exp2 u_exp_ros (
		.clk(clk), .en(en), .y(y_ros), .cap(32'(1 << spfk_pkg::FRAC_BITS)), .v(ros)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_c_s[0] <= ctx;
			for (int j = 1; j < ExpLat; j++) side_c_s[j] <= side_c_s[j-1];
		end
	end

	always_comb begin
		u           = 17'(32'(1 << spfk_pkg::FRAC_BITS) - ros);
		uctx.c      = side_c_s[ExpLat-1];
		uctx.u_zero = u == 17'd0;
	end

	spfk_log2 u_log_u (.clk(clk), .en(en), .x(64'(u)), .y(lu));

	always_ff @(posedge clk) begin
		if (en) begin
			side_d_s[0] <= uctx;
			for (int j = 1; j < LogLat; j++) side_d_s[j] <= side_d_s[j-1];
		end
	end

	// exponent products: (alpha - 1) * nu and alpha * nu
	always_comb begin
		d_out   = side_d_s[LogLat-1];
		nu      = d_out.u_zero ? '0 : spfk_pkg::LOG_ONE - lu;
		am1     = d_out.c.b.alpha - AW'(spfk_pkg::ALPHA_ONE);
		pa_full = 47'(am1) * 47'(nu);
		pe_full = 47'(d_out.c.b.alpha) * 47'(nu);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s70  <= pa_full[45:16];
			pe_s70  <= pe_full[45:16];
			ctx_s70 <= d_out;
			am1_s70 <= am1;
		end
	end

	always_comb begin
		lf = -W'(pa_s70) - W'(ctx_s70.c.lsig) - W'(ctx_s70.c.lr2 >> 1)
			+ W'(ctx_s70.c.lsc) + spfk_pkg::LF_BIAS;
		le = -W'(pe_s70) - W'(ctx_s70.c.lal) + W'(ctx_s70.c.lsc) + spfk_pkg::LE_BIAS;
		fin.contact  = ctx_s70.c.b.contact;
		fin.scale_nz = ctx_s70.c.b.scale_nz;
		fin.fz       = ctx_s70.u_zero && (am1_s70 != '0);
		fin.ez       = ctx_s70.u_zero;
		fin.neg      = ctx_s70.c.b.neg;
		fin.ax       = ctx_s70.c.b.ax;
		fin.ay       = ctx_s70.c.b.ay;
		fin.az       = ctx_s70.c.b.az;
	end

	spfk_exp2 u_exp_force  (.clk(clk), .en(en), .y(lf), .cap(32'hFFFF_FFFF), .v(fp));
	spfk_exp2 u_exp_energy (.clk(clk), .en(en), .y(le), .cap(32'h0001_FFFF), .v(en_raw));

	always_ff @(posedge clk) begin
		if (en) begin
			side_f_s[0] <= fin;
			for (int j = 1; j < ExpLat; j++) side_f_s[j] <= side_f_s[j-1];
		end
	end

	// drop results for separated pairs and zero scale; where u is zero, drop the energy, and the force unless alpha is one
	always_comb begin
		f_out = side_f_s[ExpLat-1];
		fp_m  = (f_out.contact && f_out.scale_nz && !f_out.fz) ? fp : '0;
		en_m  = (f_out.contact && f_out.scale_nz && !f_out.ez) ? en_raw[16:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			contact_s93 <= f_out.contact;
			fp_s93      <= fp_m;
			en_s93      <= en_m;
			neg_s93     <= f_out.neg;
			px_s93      <= 48'((64'(f_out.ax) * 64'(fp_m)) >> spfk_pkg::FRAC_BITS);
			py_s93      <= 48'((64'(f_out.ay) * 64'(fp_m)) >> spfk_pkg::FRAC_BITS);
			pz_s93      <= 48'((64'(f_out.az) * 64'(fp_m)) >> spfk_pkg::FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			contact_s94 <= contact_s93;
			fp_s94      <= fp_s93;
			en_s94      <= en_s93;
			fx_s94      <= sat_comp(px_s93, neg_s93[0]);
			fy_s94      <= sat_comp(py_s93, neg_s93[1]);
			fz_s94      <= sat_comp(pz_s93, neg_s93[2]);
		end
	end

	assign in_contact          = contact_s94;
	assign force_over_distance = fp_s94;
	assign force_x             = signed'(fx_s94);
	assign force_y             = signed'(fy_s94);
	assign force_z             = signed'(fz_s94);
	assign pair_energy         = en_s94;

`ifndef SYNTHESIS
	a_no_contact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		force_valid && !in_contact |->
			force_over_distance == 32'd0 && pair_energy == 17'd0 && force_x == 32'sd0)
		else $error("separated pair gave nonzero result");

	a_zero_fpair_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		force_valid && force_over_distance == 32'd0 |->
			force_x == 32'sd0 && force_y == 32'sd0 && force_z == 32'sd0)
		else $error("force component without force magnitude");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		force_valid && force_stall |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> force_valid)
		else $error("input stalled with no result waiting");
`endif

endmodule

// ===== sim/soft_pair_force_kernel_test.sv =====
`timescale 1ns / 1ps

module soft_pair_force_kernel_test;

	typedef struct {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [30:0]        r1;
		logic [30:0]        r2;
		logic [16:0]        scale;
	} pair_t;

	typedef struct {
		logic               contact;
		logic [31:0]        fpair;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic [16:0]        energy;
	} force_t;

	typedef struct {
		pair_t  p;
		bit     known;
		force_t f;
	} row_t;

	localparam force_t NO_FORCE = '{1'b0, 32'd0, 32'sd0, 32'sd0, 32'sd0, 17'd0};
	localparam force_t SCALE_OFF = '{1'b1, 32'd0, 32'sd0, 32'sd0, 32'sd0, 17'd0};
	localparam longint LOG_ONE_L = longint'(spfk_pkg::FRAC_BITS) << spfk_pkg::LOG_FRAC;

	logic               clk;
	logic               arst_n;
	logic               pair_valid;
	logic               pair_stall;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic signed [31:0] delta_z;
	logic [30:0]        radius_first;
	logic [30:0]        radius_second;
	logic [16:0]        bond_scale;
	logic               softness_valid;
	logic               softness_ready;
	logic [20:0]        softness_exponent;
	logic               force_valid;
	logic               force_stall;
	logic               in_contact;
	logic [31:0]        force_over_distance;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic [16:0]        pair_energy;

	force_t      pending_forces[$];
	row_t        edge_rows[$];
	logic [20:0] alpha_reg;
	int          mismatches;
	bit          quiet;
	int          stall_left;
	int          free_left;

	soft_pair_force_kernel dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.pair_valid          (pair_valid),
		.pair_stall          (pair_stall),
		.delta_x             (delta_x),
		.delta_y             (delta_y),
		.delta_z             (delta_z),
		.radius_first        (radius_first),
		.radius_second       (radius_second),
		.bond_scale          (bond_scale),
		.softness_valid      (softness_valid),
		.softness_ready      (softness_ready),
		.softness_exponent   (softness_exponent),
		.force_valid         (force_valid),
		.force_stall         (force_stall),
		.in_contact          (in_contact),
		.force_over_distance (force_over_distance),
		.force_x             (force_x),
		.force_y             (force_y),
		.force_z             (force_z),
		.pair_energy         (pair_energy)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = x;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint log2_fix(input logic [63:0] x);
		int          msb;
		logic [63:0] m;
		logic [63:0] frac;
		msb = 0;
		frac = 64'd0;
		for (int i = 0; i < 64; i++)
			if (x[i]) msb = i;
		if (msb >= 30) m = x >> (msb - 30);
		else m = x << (30 - msb);
		for (int i = 1; i <= spfk_pkg::LOG_FRAC; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				frac = frac | (64'd1 << (spfk_pkg::LOG_FRAC - i));
				m = m >> 1;
			end
		end
		return longint'((64'(msb) << spfk_pkg::LOG_FRAC) | frac);
	endfunction

	function automatic logic [63:0] exp2_fix(input longint y, input logic [63:0] cap);
		longint      uy;
		int          k;
		int          e;
		logic [63:0] f;
		logic [63:0] res;
		logic [63:0] cur;
		logic [63:0] v;
		if (y < -(longint'(100) << spfk_pkg::LOG_FRAC))
			y = -(longint'(100) << spfk_pkg::LOG_FRAC);
		if (y > (longint'(63) << spfk_pkg::LOG_FRAC))
			y = longint'(63) << spfk_pkg::LOG_FRAC;
		uy = y + (longint'(128) << spfk_pkg::LOG_FRAC);
		k = int'(uy >>> spfk_pkg::LOG_FRAC) - 128;
		f = 64'(uy) & ((64'd1 << spfk_pkg::LOG_FRAC) - 1);
		res = 64'd1 << 30;
		cur = 64'd2 << 30;
		for (int i = 1; i <= spfk_pkg::LOG_FRAC; i++) begin
			cur = int_sqrt(cur << 30);
			if (f[spfk_pkg::LOG_FRAC - i]) res = (res * cur) >> 30;
		end
		e = k + spfk_pkg::FRAC_BITS - 30;
		if (e >= 0) begin
			if (e > 32) return cap;
			v = res << e;
		end else begin
			v = (-e >= 63) ? 64'd0 : (res >> (-e));
		end
		return (v > cap) ? cap : v;
	endfunction

	function automatic logic [31:0] scaled_component(input logic [31:0] d,
			input logic [63:0] fp);
		logic [31:0] mag;
		logic [63:0] p;
		mag = d[31] ? -d : d;
		p = (64'(mag) * fp) >> spfk_pkg::FRAC_BITS;
		if (d[31]) begin
			if (p > 64'h8000_0000) p = 64'h8000_0000;
			return -p[31:0];
		end
		if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
		return p[31:0];
	endfunction

	function automatic force_t predict_force(input pair_t p, input logic [20:0] alpha_in);
		force_t      f;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic [63:0] rsq;
		logic [63:0] sigma;
		logic [63:0] sigsq;
		logic [63:0] alpha;
		logic [63:0] am1;
		logic [63:0] ros;
		logic [63:0] u;
		logic [63:0] nu;
		logic [63:0] fp;
		logic [63:0] en;
		longint      lr2;
		longint      ls2;
		longint      lsig;
		longint      lscale;
		longint      lf;
		longint      le;
		bit          fzero;
		bit          ezero;
		f = NO_FORCE;
		nu = 64'd0;
		fp = 64'd0;
		en = 64'd0;
		fzero = 1'b0;
		ezero = 1'b0;
		ax = p.dx[31] ? -p.dx : p.dx;
		ay = p.dy[31] ? -p.dy : p.dy;
		az = p.dz[31] ? -p.dz : p.dz;
		rsq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
		sigma = 64'(p.r1) + 64'(p.r2);
		sigsq = sigma * sigma;
		if (rsq == 0 || rsq >= sigsq) return f;
		f.contact = 1'b1;
		if (p.scale == 0) return f;
		alpha = 64'(alpha_in);
		if (alpha < spfk_pkg::ALPHA_ONE) alpha = spfk_pkg::ALPHA_ONE;
		if (alpha > spfk_pkg::ALPHA_MAX) alpha = spfk_pkg::ALPHA_MAX;
		am1 = alpha - spfk_pkg::ALPHA_ONE;
		lr2 = log2_fix(rsq);
		ls2 = log2_fix(sigsq);
		lsig = log2_fix(sigma);
		lscale = log2_fix(64'(p.scale))
			- (longint'(spfk_pkg::SCALE_FRAC) << spfk_pkg::LOG_FRAC);
		ros = exp2_fix(-((ls2 - lr2) >>> 1), 64'd1 << spfk_pkg::FRAC_BITS);
		u = (64'd1 << spfk_pkg::FRAC_BITS) - ros;
		if (u == 0) begin
			ezero = 1'b1;
			if (am1 != 0) fzero = 1'b1;
		end else begin
			nu = 64'(LOG_ONE_L - log2_fix(u));
		end
		if (!fzero) begin
			lf = -longint'((am1 * nu) >> 16) - (lsig - LOG_ONE_L)
				- ((lr2 >>> 1) - LOG_ONE_L) + lscale;
			fp = exp2_fix(lf, 64'hFFFF_FFFF);
		end
		if (!ezero) begin
			le = -longint'((alpha * nu) >> 16)
				- (log2_fix(alpha) - (longint'(16) << spfk_pkg::LOG_FRAC)) + lscale;
			en = exp2_fix(le, 64'h1_FFFF);
		end
		f.fpair = fp[31:0];
		f.fx = scaled_component(p.dx, fp);
		f.fy = scaled_component(p.dy, fp);
		f.fz = scaled_component(p.dz, fp);
		f.energy = en[16:0];
		return f;
	endfunction

	task automatic send_pair(input pair_t p, input bit known, input force_t f);
		pair_valid <= 1'b1;
		delta_x <= p.dx;
		delta_y <= p.dy;
		delta_z <= p.dz;
		radius_first <= p.r1;
		radius_second <= p.r2;
		bond_scale <= p.scale;
		do @(posedge clk); while (pair_stall);
		pending_forces.push_back(known ? f : predict_force(p, alpha_reg));
		if (!quiet && $urandom_range(0, 3) == 0) begin
			pair_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic drain_forces();
		pair_valid <= 1'b0;
		while (pending_forces.size() != 0) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [20:0] v);
		softness_valid <= 1'b1;
		softness_exponent <= v;
		do @(posedge clk); while (!softness_ready);
		softness_valid <= 1'b0;
		alpha_reg = v;
	endtask

	function automatic pair_t random_pair();
		pair_t       p;
		int          sh;
		logic [63:0] lim;
		sh = $urandom_range(1, 31);
		p.r1 = 31'($urandom) & 31'((64'd1 << sh) - 1);
		p.r2 = 31'($urandom) & 31'((64'd1 << sh) - 1);
		case ($urandom_range(0, 7))
			0: p.scale = 17'd65536;
			1: p.scale = 17'd0;
			default: p.scale = 17'($urandom_range(1, 65536));
		endcase
		if ($urandom_range(0, 9) < 3) begin
			p.dx = $urandom;
			p.dy = $urandom;
			p.dz = $urandom;
			if ($urandom_range(0, 1) == 1) begin
				p.r1 = 31'($urandom);
				p.r2 = 31'($urandom);
			end
		end else begin
			// keep each component at most sigma/2 so the pair overlaps unless all three are zero
			lim = (64'(p.r1) + 64'(p.r2)) >> 1;
			if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
			lim = lim >> $urandom_range(0, 12);
			p.dx = 32'($urandom_range(0, 32'(lim)));
			p.dy = 32'($urandom_range(0, 32'(lim)));
			p.dz = 32'($urandom_range(0, 32'(lim)));
			if ($urandom_range(0, 1) == 1) p.dx = -p.dx;
			if ($urandom_range(0, 1) == 1) p.dy = -p.dy;
			if ($urandom_range(0, 1) == 1) p.dz = -p.dz;
		end
		return p;
	endfunction

	// receiver idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_stall <= 1'b0;
			stall_left <= 0;
			free_left <= 0;
		end else if (quiet) begin
			force_stall <= 1'b0;
		end else if (stall_left > 0) begin
			force_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (free_left > 0) begin
			force_stall <= 1'b0;
			free_left <= free_left - 1;
		end else begin
			force_stall <= 1'b0;
			if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 14);
			else free_left <= $urandom_range(1, 60);
		end
	end

	always @(posedge clk) begin
		if (arst_n && force_valid && !force_stall) begin
			if (pending_forces.size() == 0) begin
				$error("force item with no pair pending");
				mismatches++;
			end else begin
				force_t e;
				e = pending_forces.pop_front();
				if (in_contact !== e.contact) begin
					$error("in_contact exp %0d got %0d", e.contact, in_contact);
					mismatches++;
				end
				if (force_over_distance !== e.fpair) begin
					$error("force_over_distance exp %0h got %0h", e.fpair,
						force_over_distance);
					mismatches++;
				end
				if (force_x !== e.fx) begin
					$error("force_x exp %0h got %0h", e.fx, force_x);
					mismatches++;
				end
				if (force_y !== e.fy) begin
					$error("force_y exp %0h got %0h", e.fy, force_y);
					mismatches++;
				end
				if (force_z !== e.fz) begin
					$error("force_z exp %0h got %0h", e.fz, force_z);
					mismatches++;
				end
				if (pair_energy !== e.energy) begin
					$error("pair_energy exp %0h got %0h", e.energy, pair_energy);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		row_t        dir_rows[$];
		logic [20:0] alpha_plan[$];
		int          per_phase;
		arst_n = 1'b0;
		pair_valid = 1'b0;
		delta_x = '0;
		delta_y = '0;
		delta_z = '0;
		radius_first = '0;
		radius_second = '0;
		bond_scale = '0;
		softness_valid = 1'b0;
		softness_exponent = '0;
		alpha_reg = 21'(spfk_pkg::ALPHA_RESET);
		mismatches = 0;
		quiet = 1'b0;

		dir_rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 31'h10_0000, 31'h10_0000, 17'd65536},
			1'b1, NO_FORCE});
		dir_rows.push_back('{'{32'h7FFF_FFFF, 32'sd0, 32'sd0, 31'd0, 31'd0, 17'd65536},
			1'b1, NO_FORCE});
		dir_rows.push_back('{'{32'sd131072, 32'sd0, 32'sd0, 31'h1_0000, 31'h1_0000,
			17'd65536}, 1'b1, NO_FORCE});
		dir_rows.push_back('{'{32'sd65536, 32'sd0, 32'sd0, 31'h1_0000, 31'h1_0000, 17'd0},
			1'b1, SCALE_OFF});
		dir_rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 17'd65536}, 1'b0, NO_FORCE});
		dir_rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 17'd1}, 1'b0, NO_FORCE});
		dir_rows.push_back('{'{-32'sd3, 32'sd0, 32'sd0, 31'd2, 31'd2, 17'd65536},
			1'b0, NO_FORCE});
		dir_rows.push_back('{'{-32'sh12345, 32'sh2345, -32'sh100, 31'h3_0000, 31'h1_8000,
			17'h8000}, 1'b0, NO_FORCE});
		dir_rows.push_back('{'{32'sd0, -32'sd65536, 32'sd0, 31'd0, 31'h7FFF_FFFF,
			17'h1FFFF & 17'd65535}, 1'b0, NO_FORCE});

		// near-contact and near-center pairs, rerun under every exponent
		edge_rows.push_back('{'{32'sd1, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			17'd65536}, 1'b0, NO_FORCE});
		edge_rows.push_back('{'{32'sd131071, 32'sd0, 32'sd0, 31'h1_0000, 31'h1_0000,
			17'd65536}, 1'b0, NO_FORCE});
		edge_rows.push_back('{'{32'sd0, 32'sd0, -32'sd131070, 31'h1_0000, 31'h1_0000,
			17'd65536}, 1'b0, NO_FORCE});
		edge_rows.push_back('{'{32'sh7FFF_FFFE, 32'sd0, 32'sd0, 31'h4000_0000, 31'h3FFF_FFFF,
			17'd40000}, 1'b0, NO_FORCE});
		edge_rows.push_back('{'{32'sd40000, -32'sd40000, 32'sd40000, 31'h1_0000, 31'h1_0000,
			17'd1}, 1'b0, NO_FORCE});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_pair(dir_rows[i].p, dir_rows[i].known, dir_rows[i].f);
		foreach (edge_rows[i]) send_pair(edge_rows[i].p, 1'b0, NO_FORCE);
		drain_forces();

		alpha_plan = '{21'(spfk_pkg::ALPHA_ONE), 21'(spfk_pkg::ALPHA_MAX), 21'd0,
			21'h1F_FFFF,
			21'($urandom_range(spfk_pkg::ALPHA_ONE, spfk_pkg::ALPHA_MAX)),
			21'(spfk_pkg::ALPHA_RESET)};
		per_phase = 1900 / alpha_plan.size();
		foreach (alpha_plan[ph]) begin
			write_alpha(alpha_plan[ph]);
			if (ph == alpha_plan.size() - 1) quiet = 1'b1;
			foreach (edge_rows[i]) send_pair(edge_rows[i].p, 1'b0, NO_FORCE);
			repeat (per_phase) send_pair(random_pair(), 1'b0, NO_FORCE);
			drain_forces();
		end

		repeat (150) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
